// ----- hdl/prime_factorizer_top_defines.svh -----
// Assertion macros for the prime factorizer RTL.
// Used by the datapath; needs no other file.
`ifndef PRIME_FACTORIZER_TOP_DEFINES_SVH
`define PRIME_FACTORIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define PF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PF_ASSERT(lbl, expr, msg)
`define PF_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/pfact_pkg.sv -----
// Package for the prime factorizer: widths, constants, controller states and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfact_pkg;
    localparam int VALUE_BITS = 16;
    localparam int IN_BITS    = 16;
    localparam int PRIME_BITS = 16;
    localparam int MULT_BITS  = 4;
    localparam int D_BITS     = VALUE_BITS / 2 + 1;
    localparam int DSQ_BITS   = 2 * D_BITS;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    localparam logic [MULT_BITS-1:0]  MULT_MAX  = MULT_BITS'(15);
    localparam logic [PRIME_BITS-1:0] PRIME_TWO = PRIME_BITS'(2);
    localparam logic [D_BITS-1:0]     FIRST_DIV = D_BITS'(3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HALVE,
        ST_EMIT_TWO,
        ST_TEST,
        ST_DLOAD,
        ST_DIV,
        ST_CHECK,
        ST_EMIT_D,
        ST_FINAL,
        ST_EMIT_INV
    } t_state;

    typedef enum logic [1:0] {
        EMIT_SEL_TWO,
        EMIT_SEL_DIV,
        EMIT_SEL_REM,
        EMIT_SEL_INV
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        logic      halve;
        logic      step_d;
        logic      div_load;
        logic      div_step;
        logic      div_take;
        logic      emit;
        t_emit_sel emit_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_lt2;
        logic rem_even;
        logic mult_nz;
        logic dsq_le_rem;
        logic div_done;
        logic div_zero;
        logic rem_gt2;
        logic out_free;
    } t_dp_sts;
endpackage
`default_nettype wire

// ----- hdl/pfact_datapath.sv -----
// Datapath of the prime factorizer: remainder, trial divisor and its square,
// a bit-serial restoring divider and the output register. Uses pfact_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "prime_factorizer_top_defines.svh"
module pfact_datapath import pfact_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [IN_BITS-1:0]    i_value,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [PRIME_BITS-1:0]      o_prime_factor,
    output logic [MULT_BITS-1:0]       o_multiplicity,
    output logic                       o_last,
    output logic                       o_invalid
);
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [MULT_BITS-1:0]  r_mult, n_mult, mult_inc;
    logic [D_BITS-1:0]     r_d, n_d;
    logic [DSQ_BITS-1:0]   r_dsq, n_dsq;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [D_BITS-1:0]     r_part, n_part;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [PRIME_BITS-1:0] r_prime, n_prime;
    logic [MULT_BITS-1:0]  r_omult, n_omult;
    logic                  r_last, n_last;
    logic                  r_inv, n_inv;
    logic [D_BITS:0]       trial;
    logic [D_BITS:0]       diff;
    logic                  fits;
    logic                  out_free;

    assign mult_inc = (r_mult == MULT_MAX) ? r_mult : r_mult + MULT_BITS'(1);
    assign trial    = {r_part, r_quo[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, r_d};
    assign fits     = trial >= {1'b0, r_d};
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_rem  = r_rem;
        n_mult = r_mult;
        n_d    = r_d;
        n_dsq  = r_dsq;
        n_quo  = r_quo;
        n_part = r_part;
        n_cnt  = r_cnt;
        if (i_cmd.load) begin
            n_rem  = i_value[VALUE_BITS-1:0];
            n_mult = '0;
            n_d    = FIRST_DIV;
            n_dsq  = DSQ_BITS'(FIRST_DIV) * DSQ_BITS'(FIRST_DIV);
        end
        if (i_cmd.halve) begin
            n_rem  = r_rem >> 1;
            n_mult = mult_inc;
        end
        if (i_cmd.div_take) begin
            n_rem  = r_quo;
            n_mult = mult_inc;
        end
        if (i_cmd.emit) begin
            n_mult = '0;
        end
        if (i_cmd.step_d) begin
            n_d    = r_d + D_BITS'(2);
            n_dsq  = r_dsq + DSQ_BITS'({r_d, 2'b00}) + DSQ_BITS'(4);
            n_mult = '0;
        end
        if (i_cmd.div_load) begin
            n_quo  = r_rem;
            n_part = '0;
            n_cnt  = CNT_BITS'(VALUE_BITS - 1);
        end
        if (i_cmd.div_step) begin
            n_quo  = {r_quo[VALUE_BITS-2:0], fits};
            n_part = fits ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
            n_cnt  = r_cnt - CNT_BITS'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_prime     = r_prime;
        n_omult     = r_omult;
        n_last      = r_last;
        n_inv       = r_inv;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_inv       = 1'b0;
            unique case (i_cmd.emit_sel)
                EMIT_SEL_TWO: begin
                    n_prime = PRIME_TWO;
                    n_omult = r_mult;
                    n_last  = (r_rem == VALUE_BITS'(1));
                end
                EMIT_SEL_DIV: begin
                    n_prime = PRIME_BITS'(r_d);
                    n_omult = r_mult;
                    n_last  = (r_rem == VALUE_BITS'(1));
                end
                EMIT_SEL_REM: begin
                    n_prime = PRIME_BITS'(r_rem);
                    n_omult = MULT_BITS'(1);
                    n_last  = 1'b1;
                end
                EMIT_SEL_INV: begin
                    n_prime = '0;
                    n_omult = '0;
                    n_last  = 1'b1;
                    n_inv   = 1'b1;
                end
                default: begin
                    n_prime = '0;
                    n_omult = '0;
                    n_last  = 1'b1;
                    n_inv   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_mult  <= n_mult;
        r_d     <= n_d;
        r_dsq   <= n_dsq;
        r_quo   <= n_quo;
        r_part  <= n_part;
        r_cnt   <= n_cnt;
        r_prime <= n_prime;
        r_omult <= n_omult;
        r_last  <= n_last;
        r_inv   <= n_inv;
    end

    always_comb begin
        o_sts.in_lt2     = (i_value[VALUE_BITS-1:0] < VALUE_BITS'(2));
        o_sts.rem_even   = !r_rem[0];
        o_sts.mult_nz    = (r_mult != '0);
        o_sts.dsq_le_rem = (r_dsq <= DSQ_BITS'(r_rem));
        o_sts.div_done   = (r_cnt == '0);
        o_sts.div_zero   = (r_part == '0);
        o_sts.rem_gt2    = (r_rem > VALUE_BITS'(2));
        o_sts.out_free   = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_prime_factor = r_prime;
    assign o_multiplicity = r_omult;
    assign o_last         = r_last;
    assign o_invalid      = r_inv;

    `PF_ASSERT_IMP(a_emit_no_overwrite, i_cmd.emit, out_free, "result overwritten while stalled")
    `PF_ASSERT_IMP(a_take_exact, i_cmd.div_take, r_part == '0, "quotient taken on nonzero remainder")
    `PF_ASSERT_IMP(a_div_odd, i_cmd.div_step, r_d[0] && r_d >= FIRST_DIV, "trial divisor not odd")
endmodule
`default_nettype wire

// ----- hdl/pfact_ctrl.sv -----
// Controller state machine of the prime factorizer. It sequences the datapath
// through halving, trial divisions and result emission. Uses pfact_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfact_ctrl import pfact_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_lt2 ? ST_EMIT_INV : ST_HALVE;
                end
            end
            ST_HALVE: begin
                priority if (i_sts.rem_even) n_state = ST_HALVE;
                else if (i_sts.mult_nz)      n_state = ST_EMIT_TWO;
                else                         n_state = ST_TEST;
            end
            ST_EMIT_TWO: begin
                if (i_sts.out_free) n_state = ST_TEST;
            end
            ST_TEST: begin
                n_state = i_sts.dsq_le_rem ? ST_DLOAD : ST_FINAL;
            end
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (i_sts.div_zero) n_state = ST_DLOAD;
                else if (i_sts.mult_nz)      n_state = ST_EMIT_D;
                else                         n_state = ST_TEST;
            end
            ST_EMIT_D: begin
                if (i_sts.out_free) n_state = ST_TEST;
            end
            ST_FINAL: begin
                if (!i_sts.rem_gt2 || i_sts.out_free) n_state = ST_IDLE;
            end
            ST_EMIT_INV: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.emit_sel = EMIT_SEL_TWO;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_HALVE: begin
                o_cmd.halve = i_sts.rem_even;
            end
            ST_EMIT_TWO: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.emit_sel = EMIT_SEL_TWO;
            end
            ST_TEST: begin
            end
            ST_DLOAD: begin
                o_cmd.div_load = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.div_take = i_sts.div_zero;
                o_cmd.step_d   = !i_sts.div_zero && !i_sts.mult_nz;
            end
            ST_EMIT_D: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.step_d   = i_sts.out_free;
                o_cmd.emit_sel = EMIT_SEL_DIV;
            end
            ST_FINAL: begin
                o_cmd.emit     = i_sts.rem_gt2 && i_sts.out_free;
                o_cmd.emit_sel = EMIT_SEL_REM;
            end
            ST_EMIT_INV: begin
                o_cmd.emit     = i_sts.out_free;
                o_cmd.emit_sel = EMIT_SEL_INV;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/prime_factorizer_top.sv -----
// Top level of the prime factorizer: joins the controller and the datapath.
// Uses pfact_pkg, pfact_ctrl and pfact_datapath.
//
// The input channel (i_in_valid, o_in_ready, i_value) takes one item, an
// unsigned integer. The output channel (o_out_valid, i_out_ready) delivers one
// item per distinct prime factor in ascending order, with its multiplicity;
// o_last marks the final item of an input. Inputs 0 and 1 give a single item
// with o_invalid and o_last set and zero prime and multiplicity.
// The block works on one input at a time and raises o_in_ready again when the
// controller returns to idle after the final item is loaded into the output
// register. Factors of two are removed first by repeated halving. Every odd
// trial divisor whose square does not exceed the remainder costs a test and a
// bit-serial division (load, 16 steps, check), and the division repeats each
// time the divisor divides. When the receiver stalls, the result waits in the
// output register and the controller holds before the next emission. Reset
// empties the output register and returns the controller to idle; the input in
// work is lost.
`timescale 1ns / 1ps
`default_nettype none
module prime_factorizer_top import pfact_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [IN_BITS-1:0]    i_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [PRIME_BITS-1:0]      o_prime_factor,
    output logic [MULT_BITS-1:0]       o_multiplicity,
    output logic                       o_last,
    output logic                       o_invalid
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    pfact_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfact_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_value        (i_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_prime_factor (o_prime_factor),
        .o_multiplicity (o_multiplicity),
        .o_last         (o_last),
        .o_invalid      (o_invalid)
    );
endmodule
`default_nettype wire
